/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSP_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/ssp_pkg.sv */
`timescale 1ns / 1ps

package ssp_pkg;

  localparam logic [2:0] KIND_TICK       = 3'd0;
  localparam logic [2:0] KIND_READ_DATA  = 3'd1;
  localparam logic [2:0] KIND_READ_CTRL  = 3'd2;
  localparam logic [2:0] KIND_WRITE_DATA = 3'd3;
  localparam logic [2:0] KIND_WRITE_CTRL = 3'd4;
  localparam logic [2:0] KIND_INJECT     = 3'd5;

  localparam logic [9:0] NORMAL_CYCLES = 10'd512;
  localparam logic [9:0] FAST_CYCLES   = 10'd128;

  localparam logic [7:0] CTRL_READ_ONES = 8'h7C;
  localparam int         CTRL_INT_BIT   = 0;
  localparam int         CTRL_FAST_BIT  = 1;
  localparam int         CTRL_START_BIT = 7;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       ext_clock_edge;
    logic [7:0] write_value;
    logic [2:0] kind;
  } in_item_t;

  typedef struct packed {
    logic       irq;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_value;
  } out_item_t;

endpackage

/* rtl/core/ssp_in_reg.sv */
`timescale 1ns / 1ps

module ssp_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssp_pkg::in_item_t in_item,
  input  logic             take,
  output logic             stage_valid,
  output ssp_pkg::in_item_t stage_item
);
  import ssp_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready    = !valid_r || take;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/core/ssp_step.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssp_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  ssp_pkg::in_item_t item,
  output ssp_pkg::out_item_t result
);
  import ssp_pkg::*;

  logic [7:0] shift_data_r, shift_data_nxt;
  logic       int_clk_r, int_clk_nxt;
  logic       fast_r, fast_nxt;
  logic       active_r, active_nxt;
  logic [2:0] bit_count_r, bit_count_nxt;
  logic [9:0] cycle_count_r, cycle_count_nxt;
  logic [7:0] inj_byte_r, inj_byte_nxt;
  logic       inj_pend_r, inj_pend_nxt;

  logic       do_bit;
  logic [9:0] cnt_inc;
  logic [9:0] limit;
  logic [3:0] bc_inc;
  logic       first_bit;
  logic [2:0] rx_idx;
  logic       shift_in;
  logic [3:0] bc_done;

  always_comb begin
    shift_data_nxt  = shift_data_r;
    int_clk_nxt     = int_clk_r;
    fast_nxt        = fast_r;
    active_nxt      = active_r;
    bit_count_nxt   = bit_count_r;
    cycle_count_nxt = cycle_count_r;
    inj_byte_nxt    = inj_byte_r;
    inj_pend_nxt    = inj_pend_r;
    result          = '0;
    do_bit          = 1'b0;

    limit   = fast_r ? FAST_CYCLES : NORMAL_CYCLES;
    cnt_inc = cycle_count_r + 10'd1;
    bc_inc  = {1'b0, bit_count_r} + 4'd1;
    first_bit = (bc_inc == 4'd1);
    rx_idx  = 3'(BITS_PER_BYTE - bc_inc);
    shift_in = item.rx_valid ? item.rx_byte[rx_idx] : 1'b1;
    bc_done = bc_inc;

    unique case (item.kind)
      KIND_TICK: begin
        if (active_r) begin
          if (!int_clk_r) begin
            do_bit = item.ext_clock_edge;
          end else if (cnt_inc >= limit) begin
            cycle_count_nxt = '0;
            do_bit = 1'b1;
          end else begin
            cycle_count_nxt = cnt_inc;
          end
        end
      end
      KIND_READ_DATA: begin
        result.read_value = shift_data_r;
      end
      KIND_READ_CTRL: begin
        result.read_value = CTRL_READ_ONES;
        result.read_value[CTRL_INT_BIT]   = int_clk_r;
        result.read_value[CTRL_FAST_BIT]  = fast_r;
        result.read_value[CTRL_START_BIT] = active_r;
      end
      KIND_WRITE_DATA: begin
        shift_data_nxt = item.write_value;
      end
      KIND_WRITE_CTRL: begin
        int_clk_nxt = item.write_value[CTRL_INT_BIT];
        fast_nxt    = item.write_value[CTRL_FAST_BIT];
        active_nxt  = item.write_value[CTRL_START_BIT];
        if (!active_r && item.write_value[CTRL_START_BIT]) begin
          bit_count_nxt   = '0;
          cycle_count_nxt = '0;
        end
      end
      KIND_INJECT: begin
        inj_byte_nxt = item.write_value;
        inj_pend_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_bit) begin
      if (first_bit) begin
        result.tx_valid = 1'b1;
        result.tx_byte  = shift_data_r;
      end
      if (inj_pend_r && first_bit) begin
        shift_data_nxt = inj_byte_r;
        inj_pend_nxt   = 1'b0;
        bc_done        = BITS_PER_BYTE;
      end else begin
        shift_data_nxt = {shift_data_r[6:0], shift_in};
      end
      if (bc_done >= BITS_PER_BYTE) begin
        active_nxt      = 1'b0;
        bit_count_nxt   = '0;
        cycle_count_nxt = '0;
        result.irq      = 1'b1;
      end else begin
        bit_count_nxt = bc_done[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_data_r  <= '0;
      int_clk_r     <= 1'b0;
      fast_r        <= 1'b0;
      active_r      <= 1'b0;
      bit_count_r   <= '0;
      cycle_count_r <= '0;
      inj_byte_r    <= '0;
      inj_pend_r    <= 1'b0;
    end else if (fire) begin
      shift_data_r  <= shift_data_nxt;
      int_clk_r     <= int_clk_nxt;
      fast_r        <= fast_nxt;
      active_r      <= active_nxt;
      bit_count_r   <= bit_count_nxt;
      cycle_count_r <= cycle_count_nxt;
      inj_byte_r    <= inj_byte_nxt;
      inj_pend_r    <= inj_pend_nxt;
    end
  end

  `SSP_ASSERT_NEXT(a_irq_ends_transfer, fire && result.irq, !active_r, "irq left transfer active")
  `SSP_ASSERT_IMPL(a_tx_on_first_bit, fire && result.tx_valid, active_r && bit_count_r == 3'd0, "tx outside first bit")
  `SSP_ASSERT_NEXT(a_inject_completes, fire && result.irq && result.tx_valid, shift_data_r == $past(inj_byte_r) && !inj_pend_r, "injected byte not loaded")

endmodule

/* rtl/core/ssp_out_reg.sv */
`timescale 1ns / 1ps

module ssp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ssp_pkg::out_item_t load_item,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output ssp_pkg::out_item_t out_item
);
  import ssp_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

endmodule

/* rtl/core/serial_shift_port.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in_       slave      in_tvalid / in_tready   tdata 24b, tuser 3b (kind)
// out_      master     out_tvalid / out_tready tdata 24b
//
// One transaction in, one transaction out, one per cycle sustained while out_tready stays high.
// Path: an accepted input waits in the input register, then the step updates the port
// state and loads its result into the result register when that register can take it.
// Reset: synchronous and active low on rst_n; it clears all port state and both stages.
// A stalled out_tready holds the result; the input stage still fills once.

module serial_shift_port (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] write_value, [8] ext_clock_edge, [9] rx_valid, [17:10] rx_byte, [23:18] zero
  input  logic [23:0] in_tdata,
  // [2:0] kind
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_value, [8] tx_valid, [16:9] tx_byte, [17] irq, [23:18] zero
  output logic [23:0] out_tdata
);
  import ssp_pkg::*;

  in_item_t  in_item;
  in_item_t  stage_item;
  out_item_t step_result;
  out_item_t out_item;
  logic      stage_valid;
  logic      can_load;
  logic      fire;

  assign in_item.kind           = in_tuser;
  assign in_item.write_value    = in_tdata[7:0];
  assign in_item.ext_clock_edge = in_tdata[8];
  assign in_item.rx_valid       = in_tdata[9];
  assign in_item.rx_byte        = in_tdata[17:10];

  assign fire = stage_valid && can_load;

  ssp_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (in_item),
    .take        (fire),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  ssp_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (stage_item),
    .result (step_result)
  );

  ssp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_item (step_result),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {6'd0, out_item.irq, out_item.tx_byte, out_item.tx_valid,
                      out_item.read_value};

endmodule

/* sim/serial_shift_port_tb.sv */
`timescale 1ns / 1ps

module serial_shift_port_tb;
  import ssp_pkg::*;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  serial_shift_port u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Port state as the predictor sees it.
  logic [7:0] m_data = '0;
  logic       m_int = 1'b0;
  logic       m_fast = 1'b0;
  logic       m_active = 1'b0;
  logic [3:0] m_bits = '0;
  logic [9:0] m_cycles = '0;
  logic [7:0] m_inj = '0;
  logic       m_inj_pend = 1'b0;

  out_item_t pending_results[$];
  out_item_t want_r;
  out_item_t got_r;

  int  errors = 0;
  int  transactions_sent = 0;
  int  useful_items = 0;
  int  results_checked = 0;
  int  transfers_done = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  no_idle = 1'b0;

  function automatic out_item_t shift_bit(logic rxv, logic [7:0] rxb, out_item_t r);
    int   idx;
    logic b;
    m_bits = m_bits + 4'd1;
    if (m_bits == 4'd1) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = m_data;
    end
    if (m_inj_pend && m_bits == 4'd1) begin
      m_data     = m_inj;
      m_inj_pend = 1'b0;
      m_bits     = BITS_PER_BYTE;
    end else begin
      b = 1'b1;
      idx = 8 - int'(m_bits);
      if (rxv) b = rxb[idx];
      m_data = {m_data[6:0], b};
    end
    if (m_bits >= BITS_PER_BYTE) begin
      m_active = 1'b0;
      m_bits   = '0;
      m_cycles = '0;
      r.irq    = 1'b1;
    end
    return r;
  endfunction

  function automatic out_item_t predict_port_result(in_item_t it);
    out_item_t  r;
    logic       was;
    logic [9:0] lim;
    r = '0;
    case (it.kind)
      KIND_TICK: begin
        if (m_active) begin
          if (!m_int) begin
            if (it.ext_clock_edge) r = shift_bit(it.rx_valid, it.rx_byte, r);
          end else begin
            lim = m_fast ? FAST_CYCLES : NORMAL_CYCLES;
            m_cycles = m_cycles + 10'd1;
            if (m_cycles >= lim) begin
              m_cycles = '0;
              r = shift_bit(it.rx_valid, it.rx_byte, r);
            end
          end
        end
      end
      KIND_READ_DATA: r.read_value = m_data;
      KIND_READ_CTRL: begin
        r.read_value = CTRL_READ_ONES;
        r.read_value[CTRL_INT_BIT]   = m_int;
        r.read_value[CTRL_FAST_BIT]  = m_fast;
        r.read_value[CTRL_START_BIT] = m_active;
      end
      KIND_WRITE_DATA: m_data = it.write_value;
      KIND_WRITE_CTRL: begin
        was      = m_active;
        m_int    = it.write_value[CTRL_INT_BIT];
        m_fast   = it.write_value[CTRL_FAST_BIT];
        m_active = it.write_value[CTRL_START_BIT];
        if (!was && m_active) begin
          m_bits   = '0;
          m_cycles = '0;
        end
      end
      KIND_INJECT: begin
        m_inj      = it.write_value;
        m_inj_pend = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_item(logic [2:0] kind, logic [7:0] wv, logic ext,
                                         logic rxv, logic [7:0] rxb);
    in_item_t it;
    it.kind           = kind;
    it.write_value    = wv;
    it.ext_clock_edge = ext;
    it.rx_valid       = rxv;
    it.rx_byte        = rxb;
    return it;
  endfunction

  function automatic logic [7:0] ctrl_value(logic start, logic fast, logic intc);
    logic [7:0] v;
    v = 8'($urandom);
    v[CTRL_START_BIT] = start;
    v[CTRL_FAST_BIT]  = fast;
    v[CTRL_INT_BIT]   = intc;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("[%0t] mismatch on result %0d: %s got %02h want %02h",
             $realtime, results_checked, what, got, want);
    errors++;
  endtask

  task automatic send_item(in_item_t it);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, it.rx_byte, it.rx_valid, it.ext_clock_edge, it.write_value};
    in_tuser  <= it.kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    transactions_sent++;
    if (!(it.kind == KIND_TICK && !m_active) && it.kind <= KIND_INJECT) useful_items++;
    pending_results.push_back(predict_port_result(it));
  endtask

  task automatic send_op(logic [2:0] kind, logic [7:0] wv);
    send_item(make_item(kind, wv, 1'($urandom), 1'($urandom), 8'($urandom)));
  endtask

  task automatic send_tick(logic ext, logic rxv, logic [7:0] rxb);
    send_item(make_item(KIND_TICK, 8'($urandom), ext, rxv, rxb));
  endtask

  task automatic send_noise();
    send_item(make_item(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                        8'($urandom)));
  endtask

  task automatic send_register_op();
    send_op(3'($urandom_range(KIND_READ_DATA, KIND_INJECT)), 8'($urandom));
  endtask

  task automatic tick_until_idle(int max_ticks);
    int k;
    k = 0;
    while (m_active && k < max_ticks) begin
      send_tick(1'($urandom_range(0, 3) != 0), 1'($urandom), 8'($urandom));
      k++;
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_reset_values();
    send_op(KIND_READ_DATA, 8'hFF);
    send_op(KIND_READ_CTRL, 8'hFF);
    send_tick(1'b1, 1'b1, 8'h00);
    send_item(make_item(KIND_UNUSED_LO, 8'hFF, 1'b1, 1'b1, 8'hFF));
    send_item(make_item(KIND_UNUSED_HI, 8'h00, 1'b0, 1'b0, 8'h00));
  endtask

  task automatic test_external_transfer();
    send_op(KIND_WRITE_DATA, 8'hFF);
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b0, 1'b0));
    send_tick(1'b0, 1'b1, 8'h00);
    send_tick(1'b1, 1'b1, 8'h00);
    send_tick(1'b1, 1'b0, 8'h00);
    send_tick(1'b1, 1'b1, 8'hA5);
    send_op(KIND_READ_CTRL, 8'h00);
    tick_until_idle(64);
    send_op(KIND_READ_DATA, 8'h00);
    // internal mode ignores the external edge; then go back external keeping start
    send_op(KIND_WRITE_DATA, 8'h00);
    send_op(KIND_WRITE_CTRL, 8'hFF);
    send_tick(1'b1, 1'b1, 8'hFF);
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b0, 1'b0));
    send_op(KIND_READ_CTRL, 8'h00);
    tick_until_idle(64);
    send_op(KIND_READ_DATA, 8'h00);
  endtask

  task automatic test_injection();
    send_op(KIND_INJECT, 8'h5A);
    send_op(KIND_INJECT, 8'hA5);
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b1, 1'b0));
    send_tick(1'b1, 1'b1, 8'h00);
    send_op(KIND_READ_DATA, 8'h00);
    send_op(KIND_READ_CTRL, 8'h00);
  endtask

  task automatic test_internal_timing();
    send_op(KIND_WRITE_DATA, 8'($urandom));
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b0, 1'b1));
    repeat (662) send_tick(1'($urandom), 1'($urandom), 8'($urandom));
    // switch to fast with the count already past the fast threshold
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b1, 1'b1));
    send_tick(1'b0, 1'b1, 8'h00);
    send_op(KIND_READ_CTRL, 8'h00);
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b0, 1'b0));
    tick_until_idle(200);
    send_op(KIND_READ_DATA, 8'h00);
    // stop mid-transfer, then restart from a cleared count
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b1, 1'b1));
    repeat (280) send_tick(1'($urandom), 1'($urandom), 8'($urandom));
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b0, 1'b1, 1'b1));
    send_op(KIND_READ_CTRL, 8'h00);
    repeat (20) send_tick(1'b1, 1'($urandom), 8'($urandom));
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b1, 1'b1));
    repeat (135) send_tick(1'($urandom), 1'($urandom), 8'($urandom));
    send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'b1, 1'b0));
    tick_until_idle(200);
    drain_results();
  endtask

  task automatic run_random_transfer();
    int   sel;
    int   n;
    int   switch_at;
    logic intc;
    logic fast;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      send_noise();
    end else if (sel >= 8) begin
      send_register_op();
    end else begin
      if ($urandom_range(0, 1) != 0) send_op(KIND_WRITE_DATA, 8'($urandom));
      if ($urandom_range(0, 5) == 0) send_op(KIND_INJECT, 8'($urandom));
      intc = ($urandom_range(0, 9) == 0);
      fast = intc ? ($urandom_range(0, 3) != 0) : 1'($urandom);
      send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, fast, intc));
      switch_at = $urandom_range(100, 300);
      n = 0;
      while (m_active && n < 5000) begin
        if ($urandom_range(0, 19) == 0) begin
          send_register_op();
        end else if (m_int && n >= switch_at) begin
          send_op(KIND_WRITE_CTRL, ctrl_value(1'b1, 1'($urandom), 1'b0));
        end else begin
          send_tick(1'($urandom_range(0, 3) != 0), 1'($urandom), 8'($urandom));
        end
        n++;
      end
      if ($urandom_range(0, 1) != 0) send_op(KIND_READ_DATA, 8'($urandom));
      if ($urandom_range(0, 3) == 0) send_op(KIND_READ_CTRL, 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int goal;
    goal = transactions_sent + 180;
    while (transactions_sent < goal) begin
      run_random_transfer();
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic test_no_idle_tail();
    int goal;
    no_idle = 1'b1;
    goal = transactions_sent + 60;
    while (transactions_sent < goal) run_random_transfer();
  endtask

  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_r = out_item_t'(out_tdata[17:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, read_value", got_r.read_value, 8'h00);
      end else begin
        want_r = pending_results.pop_front();
        if (got_r.read_value !== want_r.read_value)
          report_mismatch("read_value", got_r.read_value, want_r.read_value);
        if (got_r.tx_valid !== want_r.tx_valid)
          report_mismatch("tx_valid", 8'(got_r.tx_valid), 8'(want_r.tx_valid));
        if (got_r.tx_byte !== want_r.tx_byte)
          report_mismatch("tx_byte", got_r.tx_byte, want_r.tx_byte);
        if (got_r.irq !== want_r.irq)
          report_mismatch("irq", 8'(got_r.irq), 8'(want_r.irq));
        if (want_r.irq) transfers_done++;
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL serial_shift_port");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_external_transfer();
    test_injection();
    test_internal_timing();
    test_random_traffic();
    test_no_idle_tail();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("sent %0d transactions (%0d effective), checked %0d results",
             transactions_sent, useful_items, results_checked);
    $display("covered %0d completed serial transfers, external and internal clocking",
             transfers_done);
    if (errors == 0) begin
      $display("PASS serial_shift_port");
    end else begin
      $display("FAIL serial_shift_port");
    end
    $finish;
  end

endmodule
